>>> design/assert_macros.svh
// Assertion macros shared by the line filter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define GCLF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that an expression never holds outside reset.
`define GCLF_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

>>> design/gclf_pkg.sv
// Types and constants shared by the G-code line filter.
`timescale 1ns / 1ps

package gclf_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] KIND_LINE   = 2'd0;
    localparam logic [1:0] KIND_MSG    = 2'd1;
    localparam logic [1:0] KIND_EOL    = 2'd2;
    localparam logic [1:0] KIND_CANCEL = 2'd3;

    localparam logic [2:0] CLASS_EMPTY    = 3'd0;
    localparam logic [2:0] CLASS_OVERFLOW = 3'd1;
    localparam logic [2:0] CLASS_SYSTEM   = 3'd2;
    localparam logic [2:0] CLASS_USER     = 3'd3;
    localparam logic [2:0] CLASS_BLOCKED  = 3'd4;
    localparam logic [2:0] CLASS_GCODE    = 3'd5;

    localparam logic [1:0] CFG_BLOCK_DELETE = 2'd0;
    localparam logic [1:0] CFG_MESSAGE      = 2'd1;
    localparam logic [1:0] CFG_USER_CMD     = 2'd2;

    localparam logic [7:0] CH_CAN       = 8'h18;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DOLLAR    = 8'h24;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_SEMI      = 8'h3B;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_TAG_M     = 8'h4D;
    localparam logic [7:0] CH_TAG_S     = 8'h53;
    localparam logic [7:0] CH_TAG_G     = 8'h47;
    localparam logic [7:0] CH_TAG_COMMA = 8'h2C;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       gcode_locked;
    } gclf_in_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_value;
        logic [7:0] char_position;
        logic [2:0] line_class;
        logic [7:0] line_length;
        logic       message_present;
        logic       block_deleted;
    } gclf_out_t;

    // Classified byte: tag_hit[i] means the upper-cased byte matches tag character i.
    typedef struct packed {
        logic [7:0] raw;
        logic [7:0] upc;
        logic       locked;
        logic       is_can;
        logic       is_lf;
        logic       is_cr;
        logic       is_ctrl;
        logic       is_space;
        logic       is_slash;
        logic       is_dollar;
        logic       is_bracket;
        logic       is_lparen;
        logic       is_rparen;
        logic       is_semi;
        logic [3:0] tag_hit;
    } gclf_tok_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] index;
        logic       data;
    } gclf_cfg_wr_t;

endpackage

>>> design/gclf_front.sv
// Byte classifier: decodes each received byte into flags for the line engine.
`timescale 1ns / 1ps

module gclf_front
(
    input  gclf_pkg::gclf_in_t  item,
    output gclf_pkg::gclf_tok_t tok
);

    logic [7:0] c;
    logic [7:0] upc;

    assign c = item.data_byte;

    always_comb
    begin
        if (c >= gclf_pkg::CH_LOWER_A && c <= gclf_pkg::CH_LOWER_Z)
        begin
            upc = c - gclf_pkg::CASE_OFFSET;
        end
        else
        begin
            upc = c;
        end
    end

    always_comb
    begin
        tok.raw        = c;
        tok.upc        = upc;
        tok.locked     = item.gcode_locked;
        tok.is_can     = (c == gclf_pkg::CH_CAN);
        tok.is_lf      = (c == gclf_pkg::CH_LF);
        tok.is_cr      = (c == gclf_pkg::CH_CR);
        tok.is_ctrl    = (c < gclf_pkg::CH_SPACE);
        tok.is_space   = (c == gclf_pkg::CH_SPACE);
        tok.is_slash   = (c == gclf_pkg::CH_SLASH);
        tok.is_dollar  = (c == gclf_pkg::CH_DOLLAR);
        tok.is_bracket = (c == gclf_pkg::CH_LBRACKET);
        tok.is_lparen  = (c == gclf_pkg::CH_LPAREN);
        tok.is_rparen  = (c == gclf_pkg::CH_RPAREN);
        tok.is_semi    = (c == gclf_pkg::CH_SEMI);
        tok.tag_hit[0] = (upc == gclf_pkg::CH_TAG_M);
        tok.tag_hit[1] = (upc == gclf_pkg::CH_TAG_S);
        tok.tag_hit[2] = (upc == gclf_pkg::CH_TAG_G);
        tok.tag_hit[3] = (upc == gclf_pkg::CH_TAG_COMMA);
    end

endmodule

>>> design/gclf_queue.sv
// Small first-in first-out word queue between pipeline parts.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gclf_queue
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [AW:0]      count_reg;
    logic [AW:0]      count_next;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_reg + 1'b1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_reg + 1'b1);
        end
        unique case ({wr_en, rd_en})
            2'b10:   count_next = (AW+1)'(count_reg + 1'b1);
            2'b01:   count_next = (AW+1)'(count_reg - 1'b1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `GCLF_NEVER(a_no_overrun, wr_en && full, "queue written while full")
    `GCLF_NEVER(a_no_underrun, rd_en && empty, "queue read while empty")

endmodule

>>> design/gclf_back.sv
// Line engine: carries out each classified byte against the line state.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gclf_back
#(
    parameter int LINE_LEN = 256
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  gclf_pkg::gclf_cfg_wr_t cfg,
    input  logic                   tok_valid,
    input  gclf_pkg::gclf_tok_t    tok,
    input  logic                   hold,
    output logic                   take,
    output logic                   res_valid,
    output gclf_pkg::gclf_out_t    res
);

    localparam int CW = $clog2(LINE_LEN);
    localparam int PW = (CW > 8) ? CW : 8;
    localparam logic [CW-1:0] LIMIT = CW'(LINE_LEN - 1);

    localparam int F_OVF   = 0;
    localparam int F_PAREN = 1;
    localparam int F_SEMI  = 2;
    localparam int F_CMT   = 3;
    localparam int F_BDEL  = 4;

    localparam logic [1:0] EOL_NONE = 2'd0;
    localparam logic [1:0] EOL_LF   = 2'd1;
    localparam logic [1:0] EOL_CR   = 2'd2;

    localparam logic [2:0] MSG_IDLE     = 3'd0;
    localparam logic [2:0] MSG_AT_M     = 3'd1;
    localparam logic [2:0] MSG_AT_S     = 3'd2;
    localparam logic [2:0] MSG_AT_G     = 3'd3;
    localparam logic [2:0] MSG_AT_COMMA = 3'd4;
    localparam logic [2:0] MSG_CAPTURE  = 3'd5;

    logic          bde_reg;
    logic          men_reg;
    logic          uce_reg;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [7:0]    first_reg;
    logic [7:0]    first_next;
    logic [1:0]    last_eol_reg;
    logic [1:0]    last_eol_next;
    logic [4:0]    flags_reg;
    logic [4:0]    flags_next;
    logic          no_upcase_reg;
    logic          no_upcase_next;
    logic          keep_raw_reg;
    logic          keep_raw_next;
    logic [2:0]    msg_match_reg;
    logic [2:0]    msg_match_next;
    logic [CW-1:0] msg_index_reg;
    logic [CW-1:0] msg_index_next;
    logic          msg_shown_reg;
    logic          msg_shown_next;

    logic          count_zero;
    logic          drop;
    logic          tag_ok;
    logic [1:0]    eol_code;
    logic [2:0]    line_class;
    logic [2:0]    match_new;
    logic [4:0]    flags_mid;
    logic          no_upcase_mid;
    logic [7:0]    store_val;
    logic [PW-1:0] count_ext;
    logic [PW-1:0] msg_index_ext;

    assign take          = tok_valid && !hold;
    assign count_zero    = (count_reg == '0);
    assign count_ext     = PW'(count_reg);
    assign msg_index_ext = PW'(msg_index_reg);
    assign eol_code      = tok.is_lf ? EOL_LF : EOL_CR;
    assign drop          = (no_upcase_reg ? tok.is_ctrl : (tok.is_ctrl || tok.is_space))
                           || (flags_reg != '0);

    always_comb
    begin
        unique case (msg_match_reg)
            MSG_AT_M:     tag_ok = tok.tag_hit[0];
            MSG_AT_S:     tag_ok = tok.tag_hit[1];
            MSG_AT_G:     tag_ok = tok.tag_hit[2];
            MSG_AT_COMMA: tag_ok = tok.tag_hit[3];
            default:      tag_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        priority if (flags_reg[F_OVF])
        begin
            line_class = gclf_pkg::CLASS_OVERFLOW;
        end
        else if (count_zero && !msg_shown_reg && !flags_reg[F_CMT])
        begin
            line_class = gclf_pkg::CLASS_EMPTY;
        end
        else if (!count_zero && first_reg == gclf_pkg::CH_DOLLAR)
        begin
            line_class = gclf_pkg::CLASS_SYSTEM;
        end
        else if (!count_zero && first_reg == gclf_pkg::CH_LBRACKET && uce_reg)
        begin
            line_class = gclf_pkg::CLASS_USER;
        end
        else if (tok.locked)
        begin
            line_class = gclf_pkg::CLASS_BLOCKED;
        end
        else
        begin
            line_class = gclf_pkg::CLASS_GCODE;
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        first_next     = first_reg;
        last_eol_next  = last_eol_reg;
        flags_next     = flags_reg;
        no_upcase_next = no_upcase_reg;
        keep_raw_next  = keep_raw_reg;
        msg_match_next = msg_match_reg;
        msg_index_next = msg_index_reg;
        msg_shown_next = msg_shown_reg;
        match_new      = msg_match_reg;
        flags_mid      = '0;
        no_upcase_mid  = no_upcase_reg;
        store_val      = no_upcase_reg ? tok.raw : tok.upc;
        res_valid      = 1'b0;
        res            = '0;

        if (take)
        begin
            priority if (tok.is_can)
            begin
                last_eol_next  = EOL_NONE;
                keep_raw_next  = 1'b0;
                no_upcase_next = 1'b0;
                msg_shown_next = 1'b0;
                count_next     = '0;
                flags_next     = '0;
                first_next     = '0;
                res_valid      = 1'b1;
                res.kind       = gclf_pkg::KIND_CANCEL;
            end
            else if (tok.is_lf || tok.is_cr)
            begin
                if (count_zero && last_eol_reg != EOL_NONE && last_eol_reg != eol_code)
                begin
                    last_eol_next = EOL_NONE;
                end
                else
                begin
                    last_eol_next       = eol_code;
                    res_valid           = 1'b1;
                    res.kind            = gclf_pkg::KIND_EOL;
                    res.line_class      = line_class;
                    res.line_length     = count_ext[7:0];
                    res.message_present = msg_shown_reg;
                    res.block_deleted   = flags_reg[F_BDEL];
                    keep_raw_next       = 1'b0;
                    no_upcase_next      = 1'b0;
                    msg_shown_next      = 1'b0;
                    count_next          = '0;
                    flags_next          = '0;
                    first_next          = '0;
                end
            end
            else if (drop)
            begin
                if (!tok.is_ctrl && flags_reg[F_PAREN])
                begin
                    if (msg_match_reg == MSG_CAPTURE)
                    begin
                        res_valid         = 1'b1;
                        res.kind          = gclf_pkg::KIND_MSG;
                        res.char_value    = tok.is_rparen ? 8'h00 : tok.raw;
                        res.char_position = msg_index_ext[7:0];
                        if (msg_index_reg != LIMIT)
                        begin
                            msg_index_next = CW'(msg_index_reg + 1'b1);
                        end
                    end
                    else if (tag_ok)
                    begin
                        match_new = 3'(msg_match_reg + 3'd1);
                    end
                    else
                    begin
                        match_new = MSG_IDLE;
                    end
                    msg_match_next = match_new;
                    if (tok.is_rparen)
                    begin
                        flags_next[F_PAREN] = 1'b0;
                        keep_raw_next       = 1'b0;
                        if (match_new == MSG_CAPTURE)
                        begin
                            msg_shown_next = 1'b1;
                        end
                    end
                end
            end
            else
            begin
                if (tok.is_slash && count_zero)
                begin
                    flags_mid[F_BDEL] = bde_reg;
                end
                if ((tok.is_dollar || tok.is_bracket) && count_zero)
                begin
                    no_upcase_mid = 1'b1;
                    keep_raw_next = 1'b1;
                end
                if (tok.is_lparen || tok.is_semi)
                begin
                    if (count_zero)
                    begin
                        flags_mid[F_CMT] = 1'b1;
                    end
                    if (!keep_raw_reg)
                    begin
                        keep_raw_next = 1'b1;
                        if (tok.is_lparen)
                        begin
                            flags_mid[F_PAREN] = 1'b1;
                            if (men_reg)
                            begin
                                msg_index_next = '0;
                                msg_match_next = MSG_AT_M;
                            end
                            else
                            begin
                                msg_match_next = MSG_IDLE;
                            end
                        end
                        else
                        begin
                            flags_mid[F_SEMI] = 1'b1;
                        end
                    end
                end
                no_upcase_next = no_upcase_mid;
                store_val      = no_upcase_mid ? tok.raw : tok.upc;
                if (flags_mid == '0)
                begin
                    if (count_reg == LIMIT)
                    begin
                        flags_mid[F_OVF] = 1'b1;
                    end
                    else
                    begin
                        if (count_zero)
                        begin
                            first_next = store_val;
                        end
                        res_valid         = 1'b1;
                        res.kind          = gclf_pkg::KIND_LINE;
                        res.char_value    = store_val;
                        res.char_position = count_ext[7:0];
                        count_next        = CW'(count_reg + 1'b1);
                    end
                end
                flags_next = flags_mid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bde_reg <= 1'b0;
            men_reg <= 1'b1;
            uce_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                gclf_pkg::CFG_BLOCK_DELETE: bde_reg <= cfg.data;
                gclf_pkg::CFG_MESSAGE:      men_reg <= cfg.data;
                gclf_pkg::CFG_USER_CMD:     uce_reg <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            first_reg     <= '0;
            last_eol_reg  <= EOL_NONE;
            flags_reg     <= '0;
            no_upcase_reg <= 1'b0;
            keep_raw_reg  <= 1'b0;
            msg_match_reg <= MSG_IDLE;
            msg_index_reg <= '0;
            msg_shown_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            first_reg     <= first_next;
            last_eol_reg  <= last_eol_next;
            flags_reg     <= flags_next;
            no_upcase_reg <= no_upcase_next;
            keep_raw_reg  <= keep_raw_next;
            msg_match_reg <= msg_match_next;
            msg_index_reg <= msg_index_next;
            msg_shown_reg <= msg_shown_next;
        end
    end

    `GCLF_NEVER(a_count_in_range, count_reg > LIMIT, "line count past limit")
    `GCLF_NEVER(a_msg_index_in_range, msg_index_reg > LIMIT, "message index past limit")
    `GCLF_ASSERT(a_eol_clears_line, (res_valid && res.kind == gclf_pkg::KIND_EOL) |=> (count_reg == '0 && flags_reg == '0), "line state kept after end of line")
    `GCLF_ASSERT(a_msg_only_capturing, (res_valid && res.kind == gclf_pkg::KIND_MSG) |-> (msg_match_reg == MSG_CAPTURE && flags_reg[F_PAREN]), "message word outside capture")

endmodule

>>> design/gcode_line_filter.sv
// Top level of the G-code input line filter.
//
//  channel  | handshake           | word
//  ---------+---------------------+--------------------------------------------
//  item     | push / full         | gclf_in_t: data_byte, gcode_locked
//  result   | pop / empty         | gclf_out_t: kind .. block_deleted
//  config   | cfg_valid/cfg_ready | cfg_index (register), cfg_data (value)
//
// One byte per cycle sustained while the output queue is not full; a byte is taken into a
// two-word queue after the classifier, and the line engine writes its result into a
// two-word output queue, from which it is popped. The line engine's state update sets
// the rate. Reset clears all line state and both queues; message capture comes up
// enabled. full rises when the input queue holds two words; the line engine holds while
// the output queue is full. cfg_ready is always high.
`timescale 1ns / 1ps

module gcode_line_filter
#(
    parameter int LINE_LEN = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  gclf_pkg::gclf_in_t  item,
    output logic                empty,
    input  logic                pop,
    output gclf_pkg::gclf_out_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic                cfg_data
);

    localparam int TOK_W = $bits(gclf_pkg::gclf_tok_t);
    localparam int OUT_W = $bits(gclf_pkg::gclf_out_t);

    gclf_pkg::gclf_tok_t    tok_in;
    gclf_pkg::gclf_tok_t    tok_out;
    gclf_pkg::gclf_out_t    res;
    gclf_pkg::gclf_cfg_wr_t cfg;
    logic [TOK_W-1:0]       tok_q;
    logic [OUT_W-1:0]       res_q;
    logic                   mid_empty;
    logic                   out_full;
    logic                   take;
    logic                   res_valid;

    assign cfg_ready = 1'b1;
    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;
    assign tok_out   = tok_q;
    assign result    = res_q;

    gclf_front u_front
    (
        .item (item),
        .tok  (tok_in)
    );

    gclf_queue
    #(
        .WIDTH (TOK_W),
        .DEPTH (gclf_pkg::QUEUE_DEPTH)
    )
    u_mid_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && !full),
        .wr_data (tok_in),
        .full    (full),
        .rd_en   (take),
        .rd_data (tok_q),
        .empty   (mid_empty)
    );

    gclf_back
    #(
        .LINE_LEN (LINE_LEN)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .tok_valid (!mid_empty),
        .tok       (tok_out),
        .hold      (out_full),
        .take      (take),
        .res_valid (res_valid),
        .res       (res)
    );

    gclf_queue
    #(
        .WIDTH (OUT_W),
        .DEPTH (gclf_pkg::QUEUE_DEPTH)
    )
    u_out_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (take && res_valid),
        .wr_data (res),
        .full    (out_full),
        .rd_en   (pop && !empty),
        .rd_data (res_q),
        .empty   (empty)
    );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for gcode_line_filter: queued byte stimulus, scoreboard of result words.

module testbench;

    localparam int LINE_LEN    = 256;
    localparam int LINE_LIMIT  = LINE_LEN - 1;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE      = 8;
    localparam int LONG_STALL  = 80;
    localparam int STALL_EVERY = 150;
    localparam int MAX_REPORTS = 10;
    localparam int PHASE_BYTES = 90;

    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam logic [4:0] FLAG_OVERFLOW  = 5'h01;
    localparam logic [4:0] FLAG_PAREN     = 5'h02;
    localparam logic [4:0] FLAG_SEMI      = 5'h04;
    localparam logic [4:0] FLAG_COMMENT   = 5'h08;
    localparam logic [4:0] FLAG_BLOCK_DEL = 5'h10;

    localparam logic [2:0] TAG_IDLE = 3'd0;
    localparam logic [2:0] TAG_OPEN = 3'd1;
    localparam logic [2:0] TAG_DONE = 3'd5;
    localparam logic [1:4][7:0] MSG_TAG = {gclf_pkg::CH_TAG_M, gclf_pkg::CH_TAG_S,
                                           gclf_pkg::CH_TAG_G, gclf_pkg::CH_TAG_COMMA};

    localparam int SHAPE_RANDOM   = 0;
    localparam int SHAPE_PLAIN    = 1;
    localparam int SHAPE_NOISE    = 2;
    localparam int SHAPE_OVERFLOW = 3;
    localparam int SHAPE_LONG_MSG = 4;

    // block delete, message, user command per phase
    localparam logic [0:4][2:0] PHASE_REGS = {3'b101, 3'b111, 3'b000, 3'b011, 3'b110};
    localparam logic [0:4][3:0] PHASE_SEND = {4'd0, 4'd12, 4'd12, 4'd0, 4'd5};
    localparam logic [0:4][3:0] PHASE_SINK = {4'd0, 4'd12, 4'd0, 4'd12, 4'd5};

    typedef enum logic [1:0] {EOL_NONE, EOL_LF, EOL_CR} eol_t;

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    gclf_pkg::gclf_in_t  item;
    logic                empty;
    logic                pop;
    gclf_pkg::gclf_out_t result;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    logic                cfg_data;

    gclf_pkg::gclf_in_t  bytes_to_send[$];
    gclf_pkg::gclf_out_t expected_words[$];

    logic byte_taken;
    logic word_taken;
    logic all_drained;
    int   queued = 0;
    int   mismatches = 0;
    int   quiet = 0;
    int   backlog = 0;
    int   send_gap = 0;
    int   sink_gap = 0;
    int   sink_hold = 0;
    int   sink_since_stall = 0;
    int   send_idle_max = 0;
    int   sink_idle_max = 0;

    bit         bd_enable;
    bit         msg_enable;
    bit         user_enable;
    int         stored_count;
    logic [7:0] first_char;
    eol_t       last_eol;
    logic [4:0] line_marks;
    bit         no_upcase;
    bit         keep_raw;
    logic [2:0] msg_match;
    int         msg_index;
    bit         msg_shown;

    gcode_line_filter #(.LINE_LEN(LINE_LEN)) u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return (c >= gclf_pkg::CH_LOWER_A && c <= gclf_pkg::CH_LOWER_Z) ?
               c - gclf_pkg::CASE_OFFSET : c;
    endfunction

    function automatic void clear_line();
        keep_raw = 1'b0;
        no_upcase = 1'b0;
        msg_shown = 1'b0;
        stored_count = 0;
        line_marks = '0;
        first_char = '0;
    endfunction

    function automatic bit filter_byte(input gclf_pkg::gclf_in_t w,
                                       output gclf_pkg::gclf_out_t r);
        logic [7:0] c;
        logic [7:0] v;
        eol_t       code;
        bit         hit;
        c = w.data_byte;
        r = '0;
        hit = 1'b0;
        if (c == gclf_pkg::CH_CAN)
        begin
            last_eol = EOL_NONE;
            clear_line();
            r.kind = gclf_pkg::KIND_CANCEL;
            return 1'b1;
        end
        if (c == gclf_pkg::CH_LF || c == gclf_pkg::CH_CR)
        begin
            code = (c == gclf_pkg::CH_LF) ? EOL_LF : EOL_CR;
            if (stored_count == 0 && last_eol != EOL_NONE && last_eol != code)
            begin
                last_eol = EOL_NONE;
                return 1'b0;
            end
            last_eol = code;
            r.kind = gclf_pkg::KIND_EOL;
            if ((line_marks & FLAG_OVERFLOW) != 0)
                r.line_class = gclf_pkg::CLASS_OVERFLOW;
            else if (stored_count == 0 && !msg_shown && (line_marks & FLAG_COMMENT) == 0)
                r.line_class = gclf_pkg::CLASS_EMPTY;
            else if (stored_count != 0 && first_char == gclf_pkg::CH_DOLLAR)
                r.line_class = gclf_pkg::CLASS_SYSTEM;
            else if (stored_count != 0 && first_char == gclf_pkg::CH_LBRACKET &&
                     user_enable)
                r.line_class = gclf_pkg::CLASS_USER;
            else if (w.gcode_locked)
                r.line_class = gclf_pkg::CLASS_BLOCKED;
            else
                r.line_class = gclf_pkg::CLASS_GCODE;
            r.line_length = 8'(stored_count);
            r.message_present = msg_shown;
            r.block_deleted = (line_marks & FLAG_BLOCK_DEL) != 0;
            clear_line();
            return 1'b1;
        end
        if (c < gclf_pkg::CH_SPACE || (c == gclf_pkg::CH_SPACE && !no_upcase) ||
            line_marks != 0)
        begin
            if (c >= gclf_pkg::CH_SPACE && (line_marks & FLAG_PAREN) != 0)
            begin
                if (msg_match == TAG_DONE)
                begin
                    r.kind = gclf_pkg::KIND_MSG;
                    r.char_value = (c == gclf_pkg::CH_RPAREN) ? 8'h00 : c;
                    r.char_position = 8'((msg_index < LINE_LIMIT) ? msg_index : LINE_LIMIT);
                    hit = 1'b1;
                    if (msg_index < LINE_LIMIT)
                        msg_index++;
                end
                else if (msg_match != TAG_IDLE && msg_match < TAG_DONE &&
                         to_upper(c) == MSG_TAG[msg_match])
                    msg_match++;
                else
                    msg_match = TAG_IDLE;
                if (c == gclf_pkg::CH_RPAREN)
                begin
                    line_marks &= ~FLAG_PAREN;
                    keep_raw = 1'b0;
                    if (msg_match == TAG_DONE)
                        msg_shown = 1'b1;
                end
            end
            return hit;
        end
        if (stored_count == 0)
        begin
            if (c == gclf_pkg::CH_SLASH)
            begin
                if (bd_enable)
                    line_marks |= FLAG_BLOCK_DEL;
                else
                    line_marks &= ~FLAG_BLOCK_DEL;
            end
            if (c == gclf_pkg::CH_DOLLAR || c == gclf_pkg::CH_LBRACKET)
            begin
                no_upcase = 1'b1;
                keep_raw = 1'b1;
            end
            if (c == gclf_pkg::CH_LPAREN || c == gclf_pkg::CH_SEMI)
                line_marks |= FLAG_COMMENT;
        end
        if (c == gclf_pkg::CH_LPAREN && !keep_raw)
        begin
            line_marks |= FLAG_PAREN;
            if (msg_enable)
            begin
                msg_index = 0;
                msg_match = TAG_OPEN;
            end
            else
                msg_match = TAG_IDLE;
            keep_raw = 1'b1;
        end
        if (c == gclf_pkg::CH_SEMI && !keep_raw)
        begin
            line_marks |= FLAG_SEMI;
            keep_raw = 1'b1;
        end
        if (line_marks == 0)
        begin
            if (stored_count >= LINE_LIMIT)
                line_marks |= FLAG_OVERFLOW;
            else
            begin
                v = no_upcase ? c : to_upper(c);
                if (stored_count == 0)
                    first_char = v;
                r.kind = gclf_pkg::KIND_LINE;
                r.char_value = v;
                r.char_position = 8'(stored_count);
                stored_count++;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic string word_text(input gclf_pkg::gclf_out_t w);
        return $sformatf("kind=%0d char=%02h pos=%0d class=%0d len=%0d msg=%0b bdel=%0b",
                         w.kind, w.char_value, w.char_position, w.line_class,
                         w.line_length, w.message_present, w.block_deleted);
    endfunction

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        case ($urandom_range(0, 4))
            0: c = 8'($urandom_range(gclf_pkg::CH_LOWER_A, gclf_pkg::CH_LOWER_Z));
            1: c = 8'($urandom_range(gclf_pkg::CH_LOWER_A, gclf_pkg::CH_LOWER_Z))
                   - gclf_pkg::CASE_OFFSET;
            2: c = 8'($urandom_range(8'h30, 8'h39));
            3: c = gclf_pkg::CH_SPACE;
            default: c = 8'($urandom_range(8'h21, 8'h7E));
        endcase
        return (c == gclf_pkg::CH_RPAREN) ? gclf_pkg::CH_TAG_COMMA : c;
    endfunction

    task automatic queue_byte(input logic [7:0] b);
        gclf_pkg::gclf_in_t w;
        w.data_byte = b;
        w.gcode_locked = 1'($urandom_range(0, 1));
        bytes_to_send.push_back(w);
        queued++;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i]);
    endtask

    task automatic add_line(input int shape);
        int r;
        if (shape == SHAPE_RANDOM)
        begin
            r = $urandom_range(0, 59);
            shape = (r == 0) ? SHAPE_OVERFLOW : (r == 1) ? SHAPE_LONG_MSG :
                    (r < 8) ? SHAPE_NOISE : SHAPE_PLAIN;
        end
        case (shape)
            SHAPE_NOISE:
                repeat ($urandom_range(1, 6))
                    queue_byte(8'($urandom_range(0, 255)));
            SHAPE_OVERFLOW:
                repeat ($urandom_range(260, 300))
                    queue_byte(8'($urandom_range(gclf_pkg::CH_LOWER_A,
                                                 gclf_pkg::CH_LOWER_Z)));
            SHAPE_LONG_MSG:
            begin
                queue_text("(MSG,");
                repeat ($urandom_range(258, 280))
                    queue_byte(text_char());
                queue_byte(gclf_pkg::CH_RPAREN);
            end
            default:
            begin
                case ($urandom_range(0, 9))
                    0: queue_byte(gclf_pkg::CH_DOLLAR);
                    1: queue_byte(gclf_pkg::CH_LBRACKET);
                    2: queue_byte(gclf_pkg::CH_SLASH);
                    3: queue_byte(gclf_pkg::CH_LPAREN);
                    4: queue_byte(gclf_pkg::CH_SEMI);
                    5: queue_byte(gclf_pkg::CH_SPACE);
                    default: ;
                endcase
                repeat ($urandom_range(0, 12))
                begin
                    r = $urandom_range(0, 19);
                    if (r == 0)
                    begin
                        case ($urandom_range(0, 4))
                            0: queue_text("(MSG,");
                            1: queue_text("(msg,");
                            2: queue_text("(MsG,");
                            3: queue_text("(MS");
                            default: queue_byte(gclf_pkg::CH_LPAREN);
                        endcase
                        repeat ($urandom_range(0, 6))
                            queue_byte(text_char());
                        if ($urandom_range(0, 7) != 0)
                            queue_byte(gclf_pkg::CH_RPAREN);
                    end
                    else if (r == 1)
                        queue_byte(gclf_pkg::CH_SEMI);
                    else if (r == 2)
                        queue_byte(8'($urandom_range(0, 255)));
                    else
                        queue_byte(text_char());
                end
            end
        endcase
        if (shape == SHAPE_OVERFLOW || shape == SHAPE_LONG_MSG)
            queue_byte(gclf_pkg::CH_LF);
        else if (shape == SHAPE_PLAIN)
        begin
            case ($urandom_range(0, 7))
                0, 1: queue_byte(gclf_pkg::CH_LF);
                2: queue_byte(gclf_pkg::CH_CR);
                3:
                begin
                    queue_byte(gclf_pkg::CH_CR);
                    queue_byte(gclf_pkg::CH_LF);
                end
                4:
                begin
                    queue_byte(gclf_pkg::CH_LF);
                    queue_byte(gclf_pkg::CH_CR);
                end
                5: queue_byte(gclf_pkg::CH_CAN);
                6:
                begin
                    queue_byte(gclf_pkg::CH_CR);
                    queue_byte(gclf_pkg::CH_CR);
                end
                default: ;
            endcase
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (!all_drained);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    always @(negedge clk)
    begin : driver
        if (rst_n && (!push || byte_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                push <= 1'b0;
            end
            else if (bytes_to_send.size() > 0)
            begin
                item <= bytes_to_send.pop_front();
                push <= 1'b1;
                send_gap = $urandom_range(0, send_idle_max);
            end
            else
                push <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : receiver
        if (rst_n)
        begin
            if (word_taken)
            begin
                sink_gap = $urandom_range(0, sink_idle_max);
                sink_since_stall++;
            end
            if (sink_hold > 0)
            begin
                sink_hold--;
                pop <= 1'b0;
            end
            else if (sink_since_stall >= STALL_EVERY && backlog > 40)
            begin
                // hold off long enough to fill both internal queues
                sink_hold = LONG_STALL - 1;
                sink_since_stall = 0;
                pop <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : monitor
        gclf_pkg::gclf_out_t want;
        gclf_pkg::gclf_out_t got;
        if (!rst_n)
        begin
            byte_taken <= 1'b0;
            word_taken <= 1'b0;
            all_drained <= 1'b0;
        end
        else
        begin
            byte_taken <= push && !full;
            word_taken <= pop && !empty;
            backlog <= bytes_to_send.size();
            if (pop && !empty)
            begin
                got = result;
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected word: %s", word_text(got));
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got.kind !== want.kind || got.char_value !== want.char_value ||
                        got.char_position !== want.char_position ||
                        got.line_class !== want.line_class ||
                        got.line_length !== want.line_length ||
                        got.message_present !== want.message_present ||
                        got.block_deleted !== want.block_deleted)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("mismatch: expected %s / got %s",
                                     word_text(want), word_text(got));
                    end
                end
            end
            if (push && !full)
            begin
                if (filter_byte(item, want))
                    expected_words.push_back(want);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    gclf_pkg::CFG_BLOCK_DELETE: bd_enable = cfg_data;
                    gclf_pkg::CFG_MESSAGE:      msg_enable = cfg_data;
                    gclf_pkg::CFG_USER_CMD:     user_enable = cfg_data;
                    default: ;
                endcase
            end
            all_drained <= bytes_to_send.size() == 0 && !push && expected_words.size() == 0;
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int phase_base;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = gclf_pkg::CFG_BLOCK_DELETE;
        cfg_data = 1'b0;
        bd_enable = 1'b0;
        msg_enable = 1'b1;
        user_enable = 1'b0;
        clear_line();
        last_eol = EOL_NONE;
        msg_match = TAG_IDLE;
        msg_index = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_max = 3;
        sink_idle_max = 3;
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_text("a");
        queue_byte(gclf_pkg::CH_CAN);
        queue_text("$x");
        queue_byte(gclf_pkg::CH_CR);
        queue_byte(gclf_pkg::CH_LF);
        queue_text("(msg,A)");
        queue_byte(gclf_pkg::CH_LF);
        queue_byte(gclf_pkg::CH_CR);
        queue_byte(gclf_pkg::CH_CR);
        queue_text("[;");
        queue_byte(gclf_pkg::CH_LF);
        wait_drained();

        for (int p = 0; p < 5; p++)
        begin
            send_idle_max = PHASE_SEND[p];
            sink_idle_max = PHASE_SINK[p];
            write_reg(gclf_pkg::CFG_BLOCK_DELETE, PHASE_REGS[p][2]);
            write_reg(gclf_pkg::CFG_MESSAGE, PHASE_REGS[p][1]);
            write_reg(gclf_pkg::CFG_USER_CMD, PHASE_REGS[p][0]);
            if (p == 0)
                write_reg(CFG_UNUSED, 1'($urandom_range(0, 1)));
            @(negedge clk);
            cfg_valid <= 1'b0;
            if (p == 1)
                add_line(SHAPE_OVERFLOW);
            if (p == 3)
                add_line(SHAPE_LONG_MSG);
            phase_base = queued;
            while (queued - phase_base < PHASE_BYTES)
                add_line(SHAPE_RANDOM);
            wait_drained();
        end

        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
